// File: sv/r2h_pkg.sv
// ----------------------------------------------------------------------------
// r2h_pkg
// types, constants and divider step functions for the rgb to hsv converter
// ----------------------------------------------------------------------------
package r2h_pkg;

    localparam int ChanW    = 8;
    localparam int FracW    = 16;
    localparam int HueW     = 11;
    localparam int SatFull  = 16'hFFFF;

    localparam int StepsPerStage = 2;
    localparam int DivStages     = FracW / StepsPerStage;
    localparam int NumStages     = DivStages + 1;

    typedef logic [ChanW-1:0] t_chan;
    typedef logic [HueW-1:0]  t_hval;
    typedef logic [FracW-1:0] t_frac;

    typedef struct packed {
        logic  q;
        t_chan rem;
    } t_sat_step;

    typedef struct packed {
        logic  q;
        t_hval rem;
    } t_hue_step;

    // one restoring division step, remainder kept below the divisor
    function automatic t_sat_step sat_step(input t_chan rem, input t_chan dv);
        logic [ChanW:0] t;
        t_sat_step      res;
        t = {rem, 1'b0};
        if (t >= {1'b0, dv}) begin
            res.q   = 1'b1;
            res.rem = t_chan'(t - {1'b0, dv});
        end else begin
            res.q   = 1'b0;
            res.rem = t_chan'(t);
        end
        return res;
    endfunction

    function automatic t_hue_step hue_step(input t_hval rem, input t_hval dv);
        logic [HueW:0] t;
        t_hue_step     res;
        t = {rem, 1'b0};
        if (t >= {1'b0, dv}) begin
            res.q   = 1'b1;
            res.rem = t_hval'(t - {1'b0, dv});
        end else begin
            res.q   = 1'b0;
            res.rem = t_hval'(t);
        end
        return res;
    endfunction

endpackage

// File: sv/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Takes one 8-bit rgb pixel per clock while not stalled and gives hue and
// saturation as 0.16 fractions and value as the largest channel. The first
// stage finds max, min and the hue numerator; eight further stages each work
// out two quotient bits of the saturation and hue divisions side by side.
// One word enters every cycle while the output takes words; the sixteen
// quotient bits at two per stage set the number of divider stages. Stages
// with no word fill while the output is stalled, so the input keeps taking
// words until the pipeline is full.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter
    import r2h_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // red, green, blue
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // hue, saturation, value
);

    logic [NumStages-1:0] r_vld;
    logic [NumStages-1:0] en;

    t_chan r_mx   [NumStages];
    t_chan r_sdv  [NumStages];
    t_chan r_srem [NumStages];
    t_frac r_sq   [NumStages];
    logic  r_sful [NumStages];
    t_hval r_hdv  [NumStages];
    t_hval r_hrem [NumStages];
    t_frac r_hq   [NumStages];

    t_chan n_srem [NumStages];
    t_frac n_sq   [NumStages];
    t_hval n_hrem [NumStages];
    t_frac n_hq   [NumStages];

    t_chan in_r, in_g, in_b, mx, mn, diff;
    t_hval r11, g11, b11, d11, hnum, hdv;
    t_chan sdv, srem;
    logic  sful;

    // stage enables: a stage moves when empty or when its successor moves
    always_comb begin
        en[NumStages-1] = !r_vld[NumStages-1] || i_m_axis_tready;
        for (int k = NumStages - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[0];

    // front stage
    always_comb begin
        in_r = i_s_axis_tdata[7:0];
        in_g = i_s_axis_tdata[15:8];
        in_b = i_s_axis_tdata[23:16];
        mx   = (in_r >= in_g) ? in_r : in_g;
        mx   = (mx >= in_b) ? mx : in_b;
        mn   = (in_r <= in_g) ? in_r : in_g;
        mn   = (mn <= in_b) ? mn : in_b;
        diff = mx - mn;
        r11  = t_hval'(in_r);
        g11  = t_hval'(in_g);
        b11  = t_hval'(in_b);
        d11  = t_hval'(diff);

        if (mx == in_r) begin
            if (in_g >= in_b) begin
                hnum = g11 - b11;
            end else begin
                hnum = (d11 << 2) + (d11 << 1) - (b11 - g11);
            end
        end else if (mx == in_g) begin
            hnum = (d11 << 1) + b11 - r11;
        end else begin
            hnum = (d11 << 2) + r11 - g11;
        end

        if (diff == '0) begin
            hnum = '0;
            hdv  = t_hval'(1);
        end else begin
            hdv  = (d11 << 2) + (d11 << 1);
        end

        if (mx == '0) begin
            sdv  = t_chan'(1);
            srem = '0;
            sful = 1'b0;
        end else begin
            sdv  = mx;
            srem = diff;
            sful = (diff == mx);
        end
    end

    // divider stages
    always_comb begin
        t_sat_step ss;
        t_hue_step hs;
        n_srem[0] = srem;
        n_sq[0]   = '0;
        n_hrem[0] = hnum;
        n_hq[0]   = '0;
        for (int k = 1; k < NumStages; k++) begin
            n_srem[k] = r_srem[k-1];
            n_sq[k]   = r_sq[k-1];
            n_hrem[k] = r_hrem[k-1];
            n_hq[k]   = r_hq[k-1];
            for (int j = 0; j < StepsPerStage; j++) begin
                ss        = sat_step(n_srem[k], r_sdv[k-1]);
                hs        = hue_step(n_hrem[k], r_hdv[k-1]);
                n_srem[k] = ss.rem;
                n_sq[k]   = {n_sq[k][FracW-2:0], ss.q};
                n_hrem[k] = hs.rem;
                n_hq[k]   = {n_hq[k][FracW-2:0], hs.q};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NumStages; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_mx[0]   <= mx;
            r_sdv[0]  <= sdv;
            r_sful[0] <= sful;
            r_hdv[0]  <= hdv;
            r_srem[0] <= n_srem[0];
            r_sq[0]   <= n_sq[0];
            r_hrem[0] <= n_hrem[0];
            r_hq[0]   <= n_hq[0];
        end
        for (int k = 1; k < NumStages; k++) begin
            if (en[k]) begin
                r_mx[k]   <= r_mx[k-1];
                r_sdv[k]  <= r_sdv[k-1];
                r_sful[k] <= r_sful[k-1];
                r_hdv[k]  <= r_hdv[k-1];
                r_srem[k] <= n_srem[k];
                r_sq[k]   <= n_sq[k];
                r_hrem[k] <= n_hrem[k];
                r_hq[k]   <= n_hq[k];
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[NumStages-1];
    assign o_m_axis_tdata  = {r_mx[NumStages-1],
                              r_sful[NumStages-1] ? t_frac'(SatFull) : r_sq[NumStages-1],
                              r_hq[NumStages-1]};

    // black pixel gives zero hue and saturation
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[39:32] == '0) |->
            (o_m_axis_tdata[31:0] == '0))
        else $error("black pixel with nonzero hue or saturation");

    // zero saturation only for grey, which has zero hue
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[31:16] == '0) |->
            (o_m_axis_tdata[15:0] == '0))
        else $error("zero saturation with nonzero hue");

    // an empty output stage lets the whole pipeline move
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output stage");

    // a stalled output word is not overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled output word changed");

endmodule
